>>> rtl/cbsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column box-sum filter package
// Register codes, field widths and shared types for the column box-sum filter.
// ----------------------------------------------------------------------------
package cbsf_pkg;

  // The radius registers are 5 bits wide, so neither radius reaches past 31 samples.
  localparam int RADIUS_BITS = 5;
  localparam int RADIUS_MAX  = 31;

  // Results not yet given for received samples: 0 up to RADIUS_MAX + 1.
  localparam int PEND_BITS = 6;
  // Samples received in the current column, saturating.
  localparam int SEEN_BITS = 7;

  typedef logic [RADIUS_BITS-1:0] radius_t;
  typedef logic [PEND_BITS-1:0]   pend_t;
  typedef logic [SEEN_BITS-1:0]   seen_t;
  typedef logic [0:0]             reg_idx_t;

  localparam reg_idx_t REG_RADIUS_BEFORE = 1'b0;
  localparam reg_idx_t REG_RADIUS_AFTER  = 1'b1;

  localparam radius_t RADIUS_RESET = 5'd1;
  localparam seen_t   SEEN_LIMIT   = 7'd127;

endpackage

>>> rtl/cbsf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column box-sum filter delay cell
// One stage of the delay line; holds one running column sum and passes it on
// to the next cell whenever a new sample enters the line.
// ----------------------------------------------------------------------------
module cbsf_cell #(
  parameter int W = 22
) (
  input  logic         clk_i,
  input  logic         shift_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sum_q <= d_i;
    end
  end

  assign q_o = sum_q;

endmodule

>>> rtl/cbsf_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column box-sum filter output buffer
// Two-entry result queue that decouples the result sequencer from the
// downstream ready signal.
// ----------------------------------------------------------------------------
module cbsf_out_buf #(
  parameter int W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] entry_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   count_q;
  logic [1:0]   count_d;
  logic         pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_d = count_q + 2'(push_i) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/column_box_sum_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column box-sum filter
// Moving-window sum along a column of signed samples, with the window cut
// off at both column ends.
// ----------------------------------------------------------------------------
// Samples of one column enter on the slave stream, the last one marked by
// tlast. For each column position the block returns the exact sum of the
// samples from radius_before positions earlier to radius_after positions
// later, truncated at the column ends. A result leaves once radius_after
// further samples have arrived; the last sample of a column flushes all
// remaining results in position order. With fixed radii, while the output
// queue has room, the block takes one sample per clock cycle and returns one
// result per cycle; the last sample of a column occupies the block until it
// has flushed up to radius_after + 1 results, because the sequencer forms one
// window sum per cycle from two taps of the delay line. A result is registered
// in the output queue. No clearing pass follows reset.
module column_box_sum_filter #(
  parameter int MAX_RADIUS  = 31,
  parameter int SAMPLE_BITS = 16,
  localparam int RADIUS_EFF  = (MAX_RADIUS < cbsf_pkg::RADIUS_MAX) ?
                               MAX_RADIUS : cbsf_pkg::RADIUS_MAX,
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(2 * RADIUS_EFF + 1),
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((SUM_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  cbsf_pkg::reg_idx_t     cfg_index_i,
  input  cbsf_pkg::radius_t      cfg_wdata_i,
  // Sample stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
  input  logic                   s_axis_tlast,  // last sample of the column
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [SUM_BITS-1:0] window_sum
  output logic                   m_axis_tlast,  // last_of_run
  output logic                   m_axis_tuser   // column_done
);

  import cbsf_pkg::*;

  // The delay line holds running column sums, newest in cell 0. A window is
  // the difference of two of them, so the line spans the widest window plus
  // the sum just before it.
  localparam int      NCELLS       = 2 * RADIUS_EFF + 2;
  localparam int      IDX_BITS     = $clog2(NCELLS);
  localparam radius_t RADIUS_CLAMP = radius_t'(RADIUS_EFF);

  // Configuration registers and their clamped values.
  radius_t rb_cfg_q;
  radius_t ra_cfg_q;
  radius_t rb;
  radius_t ra;

  // Sequencer state. While busy, pend_q counts the samples of the current
  // column whose result is still owed, and target_q is the count to stop at.
  logic    busy_q,   busy_d;
  logic    last_q,   last_d;
  pend_t   pend_q,   pend_d;
  seen_t   seen_q,   seen_d;
  radius_t target_q, target_d;

  logic    has_work;
  logic    emit;
  logic    final_res;
  logic    done_now;
  logic    in_fire;
  logic    col_clear;
  pend_t   k_full;
  radius_t k;
  seen_t   seen_base;
  pend_t   pend_base;
  logic    buf_full;

  // Window geometry for the result at k positions behind the newest sample.
  seen_t                pos;
  radius_t              span_back;
  radius_t              after;
  radius_t              near_off;
  logic [RADIUS_BITS:0] far_off;
  logic                 at_start;

  logic signed [SAMPLE_BITS-1:0] sample_s;
  logic [SUM_BITS-1:0]           cum [NCELLS];
  logic [SUM_BITS-1:0]           cell_d [NCELLS];
  logic [SUM_BITS-1:0]           head_d;
  logic [SUM_BITS-1:0]           cum_near;
  logic [SUM_BITS-1:0]           cum_far;
  logic [SUM_BITS-1:0]           win_sum;
  logic [SUM_BITS+1:0]           res_in;
  logic [SUM_BITS+1:0]           res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_cfg_q <= RADIUS_RESET;
      ra_cfg_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RADIUS_BEFORE: rb_cfg_q <= cfg_wdata_i;
        REG_RADIUS_AFTER:  ra_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rb = (rb_cfg_q > RADIUS_CLAMP) ? RADIUS_CLAMP : rb_cfg_q;
  assign ra = (ra_cfg_q > RADIUS_CLAMP) ? RADIUS_CLAMP : ra_cfg_q;

  // One result per cycle while results are owed and the output queue has
  // room. The cycle that gives the final result of an item, or finds that the
  // item owes none, also takes the next sample.
  assign has_work  = ({1'b0, target_q} < pend_q);
  assign emit      = busy_q && has_work && !buf_full;
  assign k_full    = pend_q - 1'b1;
  assign k         = radius_t'(k_full);
  assign final_res = emit && (k_full == {1'b0, target_q});
  assign done_now  = busy_q && (!has_work || final_res);

  assign s_axis_tready = !busy_q || done_now;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // A finished column clears the column counters before the next sample.
  assign col_clear = done_now && last_q;
  assign seen_base = col_clear ? '0 : seen_q;
  assign pend_base = col_clear ? '0 : (emit ? k_full : pend_q);

  always_comb begin
    busy_d   = busy_q;
    last_d   = last_q;
    target_d = target_q;
    pend_d   = pend_base;
    seen_d   = seen_base;
    if (done_now) begin
      busy_d = 1'b0;
    end
    if (in_fire) begin
      busy_d   = 1'b1;
      last_d   = s_axis_tlast;
      target_d = s_axis_tlast ? '0 : ra;
      pend_d   = pend_base + 1'b1;
      seen_d   = (seen_base < SEEN_LIMIT) ? seen_base + 1'b1 : seen_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      last_q   <= 1'b0;
      target_q <= '0;
      pend_q   <= '0;
      seen_q   <= '0;
    end else begin
      busy_q   <= busy_d;
      last_q   <= last_d;
      target_q <= target_d;
      pend_q   <= pend_d;
      seen_q   <= seen_d;
    end
  end

  // The head cell starts a new running sum at the first sample of a column.
  // Sums wrap modulo 2^SUM_BITS; the difference of two of them is still exact.
  assign sample_s = s_axis_tdata[SAMPLE_BITS-1:0];
  assign head_d   = ((seen_base == '0) ? '0 : cum[0]) + SUM_BITS'(sample_s);

  for (genvar j = 0; j < NCELLS; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_d[j] = head_d;
    end else begin : g_tail
      assign cell_d[j] = cum[j-1];
    end
    cbsf_cell #(
      .W(SUM_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .shift_i(in_fire),
      .d_i    (cell_d[j]),
      .q_o    (cum[j])
    );
  end

  // The window of the position k behind the newest sample runs from
  // min(ra, k) later to min(rb, pos) earlier positions. When it reaches the
  // column start, nothing is subtracted.
  assign pos       = seen_q - seen_t'(pend_q);
  assign span_back = (seen_t'(rb) < pos) ? rb : radius_t'(pos);
  assign after     = (ra < k) ? ra : k;
  assign near_off  = k - after;
  assign far_off   = {1'b0, k} + {1'b0, span_back} + 1'b1;
  assign at_start  = (seen_t'(span_back) == pos);

  assign cum_near = cum[IDX_BITS'(near_off)];
  assign cum_far  = at_start ? '0 : cum[IDX_BITS'(far_off)];
  assign win_sum  = cum_near - cum_far;

  assign res_in = {final_res && last_q, final_res, win_sum};

  cbsf_out_buf #(
    .W(SUM_BITS + 2)
  ) u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (emit),
    .data_i (res_in),
    .full_o (buf_full),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (res_out)
  );

  assign m_axis_tdata = OUT_TDATA_W'(res_out[SUM_BITS-1:0]);
  assign m_axis_tlast = res_out[SUM_BITS];
  assign m_axis_tuser = res_out[SUM_BITS+1];

endmodule

>>> rtl/cbsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column box-sum filter port checker
// Concurrent assertions on the ports of the column box-sum filter, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module cbsf_checker #(
  parameter int IN_TDATA_W  = 16,
  parameter int OUT_TDATA_W = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tuser
);

  // The final result of a column always closes the run of its sample.
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("column_done without last_of_run");

  // A result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A sample that is not taken stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
      && $stable(s_axis_tlast))
    else $error("stalled sample changed");

  // The block only becomes busy by taking a sample.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && $past(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("sample ready dropped without a transfer");

endmodule

bind column_box_sum_filter cbsf_checker #(
  .IN_TDATA_W (IN_TDATA_W),
  .OUT_TDATA_W(OUT_TDATA_W)
) u_cbsf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
